### rtl/sqlsplit_pkg.sv
// sqlsplit_pkg: shared types, character constants and the plain-text decode function
`default_nettype none
package sqlsplit_pkg;

  // scan modes, one-hot
  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_SQUOTE  = 6'b000010,
    MODE_DQUOTE  = 6'b000100,
    MODE_SEMI    = 6'b001000,
    MODE_DASH    = 6'b010000,
    MODE_COMMENT = 6'b100000
  } mode_t;

  // characters the scanner reacts to
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       stmt_end;
    logic       last;
  } item_t;

  // decode of one input byte
  typedef struct packed {
    logic [1:0] cnt;
    item_t      r0;
    item_t      r1;
    mode_t      mode_nxt;
    logic       empty_nxt;
  } dec_t;

  // outcome of plain-text handling
  typedef struct packed {
    logic  emit;
    mode_t mode;
  } plain_t;

  function automatic plain_t plain_step(input logic [7:0] c, input logic empty);
    plain_t p;
    p.emit = 1'b0;
    p.mode = MODE_PLAIN;
    priority if (c == CH_SQUOTE) begin
      p.emit = 1'b1;
      p.mode = MODE_SQUOTE;
    end else if (c == CH_DQUOTE) begin
      p.emit = 1'b1;
      p.mode = MODE_DQUOTE;
    end else if (c == CH_SEMI) begin
      p.mode = MODE_SEMI;
    end else if (c == CH_DASH) begin
      p.mode = MODE_DASH;
    end else if (c == CH_HASH) begin
      p.mode = MODE_COMMENT;
    end else begin
      // skip leading whitespace of a statement
      p.emit = !(empty && (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE));
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/sqlsplit_decode.sv
// sqlsplit_decode: next-state and result decode for one script byte
`default_nettype none
module sqlsplit_decode
  import sqlsplit_pkg::*;
(
  input  wire logic [7:0] c,
  input  wire logic [7:0] prev,
  input  mode_t           mode,
  input  wire logic       empty,
  output dec_t            res
);

  plain_t p_cur;
  plain_t p_fresh;

  // plain handling with the current and with a fresh statement
  assign p_cur   = plain_step(c, empty);
  assign p_fresh = plain_step(c, 1'b1);

  always_comb begin
    res.cnt       = 2'd0;
    res.r0        = '{data: c, stmt_end: 1'b0, last: 1'b0};
    res.r1        = '{data: c, stmt_end: 1'b0, last: 1'b1};
    res.mode_nxt  = mode;
    res.empty_nxt = empty;
    unique case (mode)
      MODE_SQUOTE: begin
        res.cnt       = 2'd1;
        res.empty_nxt = 1'b0;
        if (c == CH_SQUOTE && prev != CH_BSLASH) res.mode_nxt = MODE_PLAIN;
      end
      MODE_DQUOTE: begin
        res.cnt       = 2'd1;
        res.empty_nxt = 1'b0;
        if (c == CH_DQUOTE && prev != CH_BSLASH) res.mode_nxt = MODE_PLAIN;
      end
      MODE_SEMI: begin
        // marker first, then the byte as plain text of a new statement
        res.r0.data     = '0;
        res.r0.stmt_end = 1'b1;
        res.mode_nxt    = p_fresh.mode;
        if (p_fresh.emit) begin
          res.cnt       = 2'd2;
          res.empty_nxt = 1'b0;
        end else begin
          res.cnt       = 2'd1;
          res.empty_nxt = 1'b1;
        end
      end
      MODE_DASH: begin
        if (c != CH_DASH) begin
          // held dash goes out with the byte behind it
          res.r0.data   = CH_DASH;
          res.cnt       = 2'd2;
          res.empty_nxt = 1'b0;
          res.mode_nxt  = MODE_PLAIN;
        end else begin
          res.mode_nxt = MODE_COMMENT;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NEWLINE) res.mode_nxt = MODE_PLAIN;
      end
      default: begin
        res.mode_nxt = p_cur.mode;
        if (p_cur.emit) begin
          res.cnt       = 2'd1;
          res.empty_nxt = 1'b0;
        end
      end
    endcase
    res.r0.last = (res.cnt == 2'd1);
  end

endmodule
`default_nettype wire

### rtl/sql_statement_splitter.sv
// sql_statement_splitter: top level with input register, scanner state and result queue
// an accepted byte waits in the input register; its decoded results go to the result queue
// throughput: one byte per cycle while bytes give at most one result each and the output
//   is not stalled; a byte giving two results sends them in turn on the one-result-per-cycle port
// the four-entry result queue parts the input side from a stalled output
// reset: synchronous, active low; plain-text mode, previous byte zero, statement empty, queue empty
`default_nettype none
module sql_statement_splitter
  import sqlsplit_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // [0] statement_end
  output logic            out_tlast   // last_of_run
);

  localparam int QDEPTH = 4;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  mode_t       mode_r;
  logic [7:0]  prev_r;
  logic        empty_r;
  item_t       q_r [QDEPTH];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  dec_t        res;
  logic        room;
  logic        adv;
  logic        pop;
  logic [2:0]  push_n;

  // decode of the registered byte
  sqlsplit_decode u_dec (
    .c     (in_byte_r),
    .prev  (prev_r),
    .mode  (mode_r),
    .empty (empty_r),
    .res   (res)
  );

  // handshake
  assign room      = (cnt_r <= 3'(QDEPTH - 2));
  assign adv       = in_vld_r && room;
  assign in_tready = !in_vld_r || room;
  assign pop       = out_tvalid && out_tready;
  assign push_n    = adv ? {1'b0, res.cnt} : 3'd0;
  assign cnt_nxt   = cnt_r + push_n - {2'b00, pop};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      prev_r  <= '0;
      empty_r <= 1'b1;
    end else if (adv) begin
      mode_r  <= res.mode_nxt;
      prev_r  <= in_byte_r;
      empty_r <= res.empty_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (adv && res.cnt != 2'd0) q_r[wr_ptr_r] <= res.r0;
    if (adv && res.cnt == 2'd2) q_r[wr_ptr_r + 2'd1] <= res.r1;
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[1:0];
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  // output side
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = q_r[rd_ptr_r].data;
  assign out_tuser  = q_r[rd_ptr_r].stmt_end;
  assign out_tlast  = q_r[rd_ptr_r].last;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("result queue overfilled");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !room |=> in_vld_r && $stable(in_byte_r))
    else $error("stalled byte lost");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.cnt == 2'd2 |-> !res.r0.last && res.r1.last)
    else $error("last flag on wrong result of a pair");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00)
    else $error("marker carries data");

  a_empty_after_marker: assert property (@(posedge clk) disable iff (!rst_n)
    adv && mode_r == MODE_SEMI && res.cnt == 2'd1 |=> empty_r)
    else $error("statement not empty after marker");

endmodule
`default_nettype wire

### dv/sql_statement_splitter_chk.sv
// sql_statement_splitter_chk: splits the accepted script on its own and checks every result
`timescale 1ns / 1ps
`default_nettype none
module sql_statement_splitter_chk
  import sqlsplit_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,  // [7:0] out_byte
  input  wire logic       out_tuser,  // [0] statement_end
  input  wire logic       out_tlast,  // last_of_run
  output int              fail_count,
  output int              pending
);

  // own copy of the scanner state
  mode_t      scan_mode;
  logic [7:0] prev_byte;
  logic       stmt_empty;

  // pieces caused by the byte being split, then the queue of expected pieces
  item_t run_buf [2];
  int    run_len;
  item_t stmt_piece_q [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // add one piece to the run of the current byte
  function automatic void add_piece(input logic [7:0] b, input logic is_end);
    run_buf[run_len].data     = b;
    run_buf[run_len].stmt_end = is_end;
    run_buf[run_len].last     = 1'b0;
    run_len++;
    if (!is_end)
      stmt_empty = 1'b0;
  endfunction

  // plain text decode: quotes open strings, ';' '-' are held, '#' opens a comment, leading blanks dropped
  function automatic void scan_plain(input logic [7:0] c);
    scan_mode = MODE_PLAIN;
    case (c)
      CH_SQUOTE: begin
        add_piece(c, 1'b0);
        scan_mode = MODE_SQUOTE;
      end
      CH_DQUOTE: begin
        add_piece(c, 1'b0);
        scan_mode = MODE_DQUOTE;
      end
      CH_SEMI: scan_mode = MODE_SEMI;
      CH_DASH: scan_mode = MODE_DASH;
      CH_HASH: scan_mode = MODE_COMMENT;
      default: begin
        if (!(stmt_empty && (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE)))
          add_piece(c, 1'b0);
      end
    endcase
  endfunction

  // split one accepted byte and queue the pieces it causes
  function automatic void split_byte(input logic [7:0] c);
    logic [7:0] prev;
    prev = prev_byte;
    run_len = 0;
    case (scan_mode)
      MODE_SQUOTE: begin
        add_piece(c, 1'b0);
        if (c == CH_SQUOTE && prev != CH_BSLASH)
          scan_mode = MODE_PLAIN;
      end
      MODE_DQUOTE: begin
        add_piece(c, 1'b0);
        if (c == CH_DQUOTE && prev != CH_BSLASH)
          scan_mode = MODE_PLAIN;
      end
      MODE_SEMI: begin
        add_piece(8'h00, 1'b1);
        stmt_empty = 1'b1;
        scan_plain(c);
      end
      MODE_DASH: begin
        // a lone dash goes out with the next byte, which is not decoded
        if (c != CH_DASH) begin
          add_piece(CH_DASH, 1'b0);
          add_piece(c, 1'b0);
          scan_mode = MODE_PLAIN;
        end else begin
          scan_mode = MODE_COMMENT;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NEWLINE)
          scan_mode = MODE_PLAIN;
      end
      default: scan_plain(c);
    endcase
    prev_byte = c;
    if (run_len > 0)
      run_buf[run_len - 1].last = 1'b1;
    for (int i = 0; i < run_len; i++)
      stmt_piece_q.push_back(run_buf[i]);
  endfunction

  // predict on every input request, compare on every output request
  always @(posedge clk) begin
    item_t exp_piece;
    if (!rst_n) begin
      scan_mode  = MODE_PLAIN;
      prev_byte  = 8'h00;
      stmt_empty = 1'b1;
      stmt_piece_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        split_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (stmt_piece_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result data=%h end=%b last=%b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          exp_piece = stmt_piece_q.pop_front();
          if (out_tdata !== exp_piece.data)
            report_mismatch($sformatf("out_byte %h, expected %h", out_tdata, exp_piece.data));
          if (out_tuser !== exp_piece.stmt_end)
            report_mismatch($sformatf("statement_end %b, expected %b",
                                      out_tuser, exp_piece.stmt_end));
          if (out_tlast !== exp_piece.last)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      out_tlast, exp_piece.last));
        end
      end
    end
    pending <= stmt_piece_q.size();
  end

endmodule
`default_nettype wire

### dv/tb_sql_statement_splitter.sv
// tb_sql_statement_splitter: clock, reset, script stimulus, back-pressure and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_sql_statement_splitter;
  import sqlsplit_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_BYTES = 150;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] text_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tuser;          // [0] statement_end
  logic       out_tlast;          // last_of_run

  int fail_count;
  int pending;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;

  sql_statement_splitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sql_statement_splitter_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // one input request, with random gaps in front; tvalid stays high between bytes sent without a gap
  task automatic send_byte(input logic [7:0] b);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] printable_byte();
    return 8'($urandom_range(32, 126));
  endfunction

  // one piece of script: mostly well-formed tokens, some noise
  task automatic send_token();
    int kind;
    int len;
    logic [7:0] q;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 30) begin
      // word
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom_range(8'h61, 8'h7A)));
    end else if (kind < 45) begin
      // whitespace run
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++)
        case ($urandom_range(2))
          0: send_byte(CH_SPACE);
          1: send_byte(CH_TAB);
          default: send_byte(CH_NEWLINE);
        endcase
    end else if (kind < 58) begin
      // quoted string with escapes
      q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      send_byte(q);
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 20) begin
          send_byte(CH_BSLASH);
          do b = printable_byte(); while (b == CH_BSLASH);
          send_byte(b);
        end else begin
          do b = printable_byte(); while (b == CH_BSLASH || b == q);
          send_byte(b);
        end
      end
      send_byte(q);
    end else if (kind < 70) begin
      // statement end, sometimes an empty statement
      send_byte(CH_SEMI);
      if ($urandom_range(3) == 0)
        send_byte(CH_SEMI);
    end else if (kind < 78) begin
      // comment up to newline
      if ($urandom_range(1)) begin
        send_byte(CH_HASH);
      end else begin
        send_byte(CH_DASH);
        send_byte(CH_DASH);
      end
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        do b = printable_byte(); while (b == CH_NEWLINE);
        send_byte(b);
      end
      send_byte(CH_NEWLINE);
    end else if (kind < 85) begin
      // lone dash and any byte after it
      send_byte(CH_DASH);
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // stop the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_sql_statement_splitter: FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [7:0] opening [26];
    int phase_end;
    opening = '{CH_SPACE, CH_TAB, 8'h00, 8'hFF, CH_SQUOTE, CH_BSLASH, CH_SQUOTE, 8'h78,
                CH_SQUOTE, CH_SEMI, CH_SEMI, CH_NEWLINE, CH_DASH, 8'h61, CH_DASH, CH_SEMI,
                CH_DASH, CH_DASH, CH_SEMI, CH_NEWLINE, CH_HASH, CH_NEWLINE, CH_DQUOTE,
                CH_BSLASH, CH_DQUOTE, CH_DQUOTE};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script: leading blanks, extremes, escapes, empty statements, dashes, comments
    foreach (opening[i])
      send_byte(opening[i]);

    // random script under four idling profiles
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end)
        send_token();
    end
    in_tvalid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0)
      $display("tb_sql_statement_splitter: PASS");
    else
      $display("tb_sql_statement_splitter: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/sqlsplit_pkg.sv
rtl/sqlsplit_decode.sv
rtl/sql_statement_splitter.sv
dv/sql_statement_splitter_chk.sv
dv/tb_sql_statement_splitter.sv
